// ----- sv/srcod_pkg.sv -----
// Shared types, constants and the bit update unit for the shift register
// chain output driver. No dependencies.
package srcod_pkg;

	// Number of chips on the chain, one shadow byte each (1 to 32).
	localparam int CHIPS = 27;
	localparam int ADDR_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;
	localparam logic [7:0] SHADOW_RST = 8'hFF;

	typedef enum logic [2:0] {
		OP_SET_SEND   = 3'd0,
		OP_CLR_SEND   = 3'd1,
		OP_READ       = 3'd2,
		OP_SET_QUIET  = 3'd3,
		OP_CLR_QUIET  = 3'd4,
		OP_SEND_ALL   = 3'd5,
		OP_SEND_BYTE  = 3'd6,
		OP_LATCH      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_LATCH = 2'd1,
		KIND_READ  = 2'd2,
		KIND_ACK   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_READ_ANS,
		ST_SEND,
		ST_SEND_OUT,
		ST_LATCH,
		ST_EMIT
	} state_t;

	// Decoded input item.
	typedef struct packed {
		op_t         op;
		logic [4:0]  chip;
		logic [2:0]  bit_sel;
		logic        bad;
		logic [7:0]  data;
	} item_t;

	// Shadow store access.
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	// Set or clear one bit of a shadow byte.
	function automatic logic [7:0] bit_update(input logic [7:0] d, input logic [2:0] sel,
	                                          input logic set);
		logic [7:0] mask;
		mask = 8'h01 << sel;
		return set ? (d | mask) : (d & ~mask);
	endfunction

endpackage

// ----- sv/srcod_if.sv -----
// Valid/ready channel interfaces for the request and result items.
// Depends on nothing.
interface srcod_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] pin_index;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, op, pin_index, data_byte, last_byte, input ready);
	modport sink (input valid, op, pin_index, data_byte, last_byte, output ready);
endinterface

interface srcod_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] shifted_byte;
	logic       pin_value;
	logic       bad_index;
	logic       last;

	modport source (output valid, kind, shifted_byte, pin_value, bad_index, last,
	                input ready);
	modport sink (input valid, kind, shifted_byte, pin_value, bad_index, last,
	              output ready);
endinterface

// ----- sv/srcod_shadow.sv -----
// Shadow byte store: one write port, one registered read port.
// Entries never written read as all ones. Depends on srcod_pkg.
module srcod_shadow (
	input  logic                clk,
	input  logic                arst_n,
	input  srcod_pkg::mem_req_t mreq,
	output logic [7:0]          rdata
);
	import srcod_pkg::*;

	logic [7:0]       mem_q [CHIPS];
	logic [CHIPS-1:0] vld_q;
	logic [7:0]       rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem_q[mreq.addr] <= mreq.wdata;
		end
		if (mreq.rd_en) begin
			rd_data_q <= mem_q[mreq.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mreq.wr_en) begin
				vld_q[mreq.addr] <= 1'b1;
			end
			if (mreq.rd_en) begin
				rd_vld_q <= vld_q[mreq.addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_data_q : SHADOW_RST;

endmodule

// ----- sv/srcod_ctrl.sv -----
// Sequencer: runs one item at a time through the shadow store and the bit
// update unit, and owns the result output register. Depends on srcod_pkg, srcod_if.
module srcod_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_fire,
	input  srcod_pkg::item_t    item,
	output logic                idle,
	output srcod_pkg::mem_req_t mreq,
	input  logic [7:0]          rdata,
	srcod_rsp_if.source         rsp
);
	import srcod_pkg::*;

	state_t            state_q, state_d;
	item_t             item_q;
	logic [ADDR_W-1:0] idx_q, idx_d;

	logic       slot_free;
	logic       emit;
	kind_t      e_kind;
	logic [7:0] e_byte;
	logic       e_pin;
	logic       e_bad;
	logic       e_last;

	logic       out_valid_q;
	kind_t      out_kind_q;
	logic [7:0] out_byte_q;
	logic       out_pin_q;
	logic       out_bad_q;
	logic       out_last_q;

	assign slot_free = !out_valid_q || rsp.ready;
	assign idle      = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= item;
		end
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		mreq       = '0;
		mreq.addr  = item_q.chip[ADDR_W-1:0];
		mreq.wdata = bit_update(rdata, item_q.bit_sel,
		                        (item_q.op == OP_SET_SEND) || (item_q.op == OP_SET_QUIET));
		emit       = 1'b0;
		e_kind     = KIND_ACK;
		e_byte     = 8'h00;
		e_pin      = 1'b0;
		e_bad      = 1'b0;
		e_last     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					idx_d = ADDR_W'(CHIPS - 1);
					if (item.bad && (item.op inside {[OP_SET_SEND:OP_CLR_QUIET]})) begin
						state_d = ST_EMIT;
					end else begin
						case (item.op)
							OP_SET_SEND, OP_CLR_SEND, OP_READ,
							OP_SET_QUIET, OP_CLR_QUIET: state_d = ST_RMW_RD;
							OP_SEND_ALL:                 state_d = ST_SEND;
							default:                     state_d = ST_EMIT;
						endcase
					end
				end
			end
			ST_RMW_RD: begin
				mreq.rd_en = 1'b1;
				state_d    = (item_q.op == OP_READ) ? ST_READ_ANS : ST_RMW_WR;
			end
			ST_RMW_WR: begin
				mreq.wr_en = 1'b1;
				if ((item_q.op == OP_SET_SEND) || (item_q.op == OP_CLR_SEND)) begin
					state_d = ST_SEND;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_READ_ANS: begin
				e_kind = KIND_READ;
				e_pin  = rdata[item_q.bit_sel];
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SEND: begin
				mreq.rd_en = 1'b1;
				mreq.addr  = idx_q;
				state_d    = ST_SEND_OUT;
			end
			ST_SEND_OUT: begin
				e_kind    = KIND_BYTE;
				e_byte    = rdata;
				e_last    = (idx_q == '0) && (item_q.op == OP_SEND_ALL);
				mreq.addr = idx_q - ADDR_W'(1);
				if (slot_free) begin
					emit = 1'b1;
					if (idx_q == '0) begin
						state_d = (item_q.op == OP_SEND_ALL) ? ST_IDLE : ST_LATCH;
					end else begin
						// fetch the next nearer chip while this byte goes out
						mreq.rd_en = 1'b1;
						idx_d      = idx_q - ADDR_W'(1);
					end
				end
			end
			ST_LATCH: begin
				e_kind = KIND_LATCH;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (item_q.bad && (item_q.op inside {[OP_SET_SEND:OP_CLR_QUIET]})) begin
					e_kind = KIND_ACK;
					e_bad  = 1'b1;
				end else begin
					case (item_q.op)
						OP_SEND_BYTE: begin
							e_kind = KIND_BYTE;
							e_byte = item_q.data;
						end
						OP_LATCH: e_kind = KIND_LATCH;
						default:  e_kind = KIND_ACK;
					endcase
				end
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= e_kind;
			out_byte_q <= e_byte;
			out_pin_q  <= e_pin;
			out_bad_q  <= e_bad;
			out_last_q <= e_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.shifted_byte = out_byte_q;
	assign rsp.pin_value    = out_pin_q;
	assign rsp.bad_index    = out_bad_q;
	assign rsp.last         = out_last_q;

endmodule

// ----- sv/shift_register_chain_output_driver.sv -----
// Top level of the shift register chain output driver: request decode,
// sequencer and shadow store. Depends on srcod_pkg, srcod_if, srcod_ctrl, srcod_shadow.
//
//  channel  role  fields                                       accepted when
//  req      sink  op, pin_index, data_byte, last_byte          valid && ready
//  rsp      src   kind, shifted_byte, pin_value, bad_index,    valid && ready
//                 last
//
// One item at a time; req.ready is high only while the sequencer is idle.
// The byte walk runs one shadow byte per cycle while rsp is ready.
// Reset (arst_n low) idles the sequencer, empties the result register and
// marks every shadow byte as all ones; no clearing pass is needed.
// A stalled rsp holds the sequencer; a new request is still taken while the
// final result of the previous item waits in the output register.
module shift_register_chain_output_driver (
	input  logic        clk,
	input  logic        arst_n,
	srcod_req_if.sink   req,
	srcod_rsp_if.source rsp
);
	import srcod_pkg::*;

	item_t      item;
	mem_req_t   mreq;
	logic [7:0] rdata;
	logic       idle;
	logic       req_fire;

	// pin number splits into chip (upper five bits) and bit (lower three)
	always_comb begin
		item.op      = op_t'(req.op);
		item.chip    = req.pin_index[7:3];
		item.bit_sel = req.pin_index[2:0];
		item.bad     = {1'b0, req.pin_index[7:3]} >= 6'(CHIPS);
		item.data    = req.data_byte;
	end

	assign req.ready = idle;
	assign req_fire  = req.valid && idle;

	srcod_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_fire (req_fire),
		.item     (item),
		.idle     (idle),
		.mreq     (mreq),
		.rdata    (rdata),
		.rsp      (rsp)
	);

	srcod_shadow u_shadow (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.rdata  (rdata)
	);

endmodule
